>>> sv/dlms_pkg.sv
// Shared types, codes and helpers for the dense layer with momentum SGD.
// No dependencies; every other file imports this package.
`default_nettype none
package dlms_pkg;

	localparam int CNT_W           = 7;
	localparam int DEF_MAX_INPUTS  = 16;
	localparam int DEF_MAX_NEURONS = 16;
	localparam int ACC_W           = 56;
	localparam int PROD_W          = 49;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 17;

	// opcodes
	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_FWD  = 3'd1;
	localparam logic [2:0] OP_ERR  = 3'd2;
	localparam logic [2:0] OP_BWD  = 3'd3;
	localparam logic [2:0] OP_WRW  = 3'd4;
	localparam logic [2:0] OP_WRB  = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEURON_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE   = 3'd4;

	localparam logic [6:0]  RST_INPUT_COUNT  = 7'd16;
	localparam logic [6:0]  RST_NEURON_COUNT = 7'd16;
	localparam logic [16:0] RST_LEARN_RATE   = 17'd7;
	localparam logic [16:0] RST_MOMENTUM     = 17'd0;
	localparam logic [15:0] RST_BATCH_SIZE   = 16'd1;

	localparam logic KIND_ACT = 1'b0;
	localparam logic KIND_ERR = 1'b1;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [5:0]         row_index;
		logic [5:0]         col_index;
		logic signed [31:0] operand;
	} cmd_t;

	typedef struct packed {
		logic               kind;
		logic [5:0]         position;
		logic signed [31:0] result_value;
		logic               last;
	} res_t;

	// effective settings: counts already clamped, batch zero already one
	typedef struct packed {
		logic [CNT_W-1:0] ni;
		logic [CNT_W-1:0] nn;
		logic [16:0]      rate;
		logic [16:0]      mom;
		logic [15:0]      batch;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > ACC_W'(64'sh7FFF_FFFF))
			r = 32'sh7FFF_FFFF;
		else if (v < ACC_W'(-64'sh8000_0000))
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

>>> sv/dense_layer_momentum_sgd.sv
// Forward: per neuron, the bias, then a read, multiply and accumulate per input.
// Backward: MACs of errors times weights, then nn*(ni+1) updates, each using
// the iterative divider and the shared multiplier.
// One command at a time; results leave through a one-word output register.
// Reset: async, active low; then a clearing pass over MAX_INPUTS*MAX_NEURONS
// addresses zeroes all memories before the first command is taken.
`default_nettype none
module dense_layer_momentum_sgd import dlms_pkg::*; #(
	parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
	parameter int MAX_NEURONS = DEF_MAX_NEURONS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire cmd_t                  cmd,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output res_t                       res
);
	logic [6:0]  in_cnt_q, neu_cnt_q;
	logic [16:0] rate_q, mom_q;
	logic [15:0] batch_q;
	cfg_t        cfg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= RST_INPUT_COUNT;
			neu_cnt_q <= RST_NEURON_COUNT;
			rate_q    <= RST_LEARN_RATE;
			mom_q     <= RST_MOMENTUM;
			batch_q   <= RST_BATCH_SIZE;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INPUT_COUNT:  in_cnt_q  <= cfg_data[6:0];
				CFG_NEURON_COUNT: neu_cnt_q <= cfg_data[6:0];
				CFG_LEARN_RATE:   rate_q    <= cfg_data;
				CFG_MOMENTUM:     mom_q     <= cfg_data;
				CFG_BATCH_SIZE:   batch_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg.ni    = (32'(in_cnt_q) > MAX_INPUTS) ? CNT_W'(MAX_INPUTS) : in_cnt_q;
	assign cfg.nn    = (32'(neu_cnt_q) > MAX_NEURONS) ? CNT_W'(MAX_NEURONS) : neu_cnt_q;
	assign cfg.rate  = rate_q;
	assign cfg.mom   = mom_q;
	assign cfg.batch = (batch_q == '0) ? 16'd1 : batch_q;

	dlms_seq #(.MAX_INPUTS(MAX_INPUTS), .MAX_NEURONS(MAX_NEURONS)) u_seq (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);
endmodule
`default_nettype wire

>>> sv/dlms_mul.sv
// Shared Q16.16 multiplier: signed product, floor shift by 16, registered.
// Depends on dlms_pkg.
`default_nettype none
module dlms_mul import dlms_pkg::*; (
	input  wire logic                     clk,
	input  wire logic signed [31:0]       a,
	input  wire logic signed [32:0]       b,
	output logic signed [PROD_W-1:0]      p_q
);
	logic signed [64:0] prod;

	assign prod = 65'(a) * 65'(b);

	// dropping the low 16 bits of a two's complement value is a floor
	always_ff @(posedge clk) begin
		p_q <= prod[64:16];
	end
endmodule
`default_nettype wire

>>> sv/dlms_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on dlms_pkg.
`default_nettype none
module dlms_div import dlms_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] dividend,
	input  wire logic [15:0]        divisor,
	output logic                    busy,
	output logic signed [31:0]      quotient
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dsr_q;
	logic        neg_q;
	logic [16:0] trial;
	logic        ge;
	logic [16:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? 32'(-dividend) : dividend;
			dsr_q <= divisor;
			neg_q <= dividend[31];
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? 32'(-quo_q) : quo_q;
endmodule
`default_nettype wire

>>> sv/dlms_seq.sv
// Sequencer and parameter memories of the layer; drives the shared
// multiplier and divider. Depends on dlms_pkg, dlms_mul, dlms_div.
`default_nettype none
module dlms_seq import dlms_pkg::*; #(
	parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
	parameter int MAX_NEURONS = DEF_MAX_NEURONS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res
);
	localparam int DEPTH = MAX_INPUTS * MAX_NEURONS;
	localparam int IAW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int NAW   = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
	localparam int WAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_ERRWR,
		S_FBIAS, S_FBLD, S_FRD, S_FMUL, S_FACC, S_FEMIT, S_FCLR,
		S_BRD, S_BMUL, S_BACC, S_BEMIT,
		S_URD, S_UGMUL, S_UGRAD, S_UDIV, S_USMUL, S_USTEP, S_UUPD
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        n_q, i_q;
	logic                    bias_q;
	logic [WAW:0]            clr_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PROD_W-1:0] step_q;
	logic [NAW-1:0]          row_q;
	logic                    row_ok_q;
	logic signed [31:0]      opnd_q;
	logic                    res_valid_q;
	res_t                    res_q;

	logic signed [31:0] w_mem  [DEPTH];
	logic signed [31:0] wv_mem [DEPTH];
	logic signed [31:0] b_mem  [MAX_NEURONS];
	logic signed [31:0] bv_mem [MAX_NEURONS];
	logic signed [31:0] a_mem  [MAX_INPUTS];
	logic signed [31:0] e_mem  [MAX_NEURONS];
	logic signed [31:0] w_rd, wv_rd, b_rd, bv_rd, a_rd, e_rd;

	logic               accept, out_free, clr_small_n, clr_small_i;
	logic [WAW-1:0]     w_addr, w_waddr;
	logic [NAW-1:0]     n_addr, e_raddr, b_waddr;
	logic [IAW-1:0]     i_addr;
	logic               w_we, wv_we, b_we, bv_we, a_we, e_we;
	logic signed [31:0] w_wd, b_wd, e_wd, v_new;
	logic               cmd_row_n_ok, cmd_row_i_ok, cmd_col_ok;
	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic               div_start, div_busy;
	logic signed [31:0] div_q, grad;
	logic               ni_zero;

	dlms_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_p));

	dlms_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(grad),
		.divisor(cfg.batch), .busy(div_busy), .quotient(div_q)
	);

	assign accept   = cmd_valid && (state_q == S_IDLE);
	assign out_free = !res_valid_q || res_ready;
	assign ni_zero  = (cfg.ni == '0);

	assign cmd_row_n_ok = 32'(cmd.row_index) < MAX_NEURONS;
	assign cmd_row_i_ok = 32'(cmd.row_index) < MAX_INPUTS;
	assign cmd_col_ok   = 32'(cmd.col_index) < MAX_INPUTS;

	assign w_addr  = WAW'(32'(n_q) * MAX_INPUTS + 32'(i_q));
	assign n_addr  = n_q[NAW-1:0];
	assign i_addr  = i_q[IAW-1:0];
	assign e_raddr = (state_q == S_IDLE) ? cmd.row_index[NAW-1:0] : n_addr;

	assign clr_small_n = 32'(clr_q) < MAX_NEURONS;
	assign clr_small_i = 32'(clr_q) < MAX_INPUTS;

	// velocity update: keep (in mul_p during S_UUPD) minus step
	assign v_new = sat32(ACC_W'(mul_p) - ACC_W'(step_q));
	assign grad  = bias_q ? e_rd : sat32(ACC_W'(mul_p));
	assign div_start = (state_q == S_UGRAD);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_FMUL: begin
				mul_a = w_rd;
				mul_b = 33'(a_rd);
			end
			S_BMUL, S_UGMUL: begin
				mul_a = e_rd;
				mul_b = (state_q == S_BMUL) ? 33'(w_rd) : 33'(a_rd);
			end
			S_USMUL: begin
				mul_a = div_q;
				mul_b = {16'd0, cfg.rate};
			end
			S_USTEP: begin
				mul_a = bias_q ? bv_rd : wv_rd;
				mul_b = {16'd0, cfg.mom};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// memory write ports
	always_comb begin
		w_we    = 1'b0;
		wv_we   = 1'b0;
		b_we    = 1'b0;
		bv_we   = 1'b0;
		a_we    = 1'b0;
		e_we    = 1'b0;
		w_waddr = w_addr;
		b_waddr = n_addr;
		w_wd    = '0;
		b_wd    = '0;
		e_wd    = '0;
		case (state_q)
			S_CLEAR: begin
				w_waddr = clr_q[WAW-1:0];
				b_waddr = clr_q[NAW-1:0];
				w_we    = 1'b1;
				wv_we   = 1'b1;
				b_we    = clr_small_n;
				bv_we   = clr_small_n;
				a_we    = clr_small_i;
				e_we    = clr_small_n;
			end
			S_IDLE: begin
				w_waddr = WAW'(32'(cmd.row_index) * MAX_INPUTS + 32'(cmd.col_index));
				b_waddr = cmd.row_index[NAW-1:0];
				w_wd    = cmd.operand;
				b_wd    = cmd.operand;
				w_we    = accept && cmd.opcode == OP_WRW && cmd_row_n_ok && cmd_col_ok;
				b_we    = accept && cmd.opcode == OP_WRB && cmd_row_n_ok;
				a_we    = accept && cmd.opcode == OP_LOAD && cmd_row_i_ok;
			end
			S_ERRWR: begin
				e_we = row_ok_q;
				e_wd = sat32(ACC_W'(e_rd) + ACC_W'(opnd_q));
			end
			S_FCLR: begin
				e_we = 1'b1;
			end
			S_UUPD: begin
				w_wd  = sat32(ACC_W'(w_rd) + ACC_W'(v_new));
				b_wd  = sat32(ACC_W'(b_rd) + ACC_W'(v_new));
				w_we  = !bias_q;
				wv_we = !bias_q;
				b_we  = bias_q;
				bv_we = bias_q;
			end
			default: begin
				w_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (w_we)
			w_mem[w_waddr] <= w_wd;
		w_rd <= w_mem[w_addr];
	end

	always_ff @(posedge clk) begin
		if (wv_we)
			wv_mem[w_waddr] <= (state_q == S_CLEAR) ? 32'sd0 : v_new;
		wv_rd <= wv_mem[w_addr];
	end

	always_ff @(posedge clk) begin
		if (b_we)
			b_mem[b_waddr] <= b_wd;
		b_rd <= b_mem[n_addr];
	end

	always_ff @(posedge clk) begin
		if (bv_we)
			bv_mem[b_waddr] <= (state_q == S_CLEAR) ? 32'sd0 : v_new;
		bv_rd <= bv_mem[n_addr];
	end

	always_ff @(posedge clk) begin
		if (a_we)
			a_mem[(state_q == S_CLEAR) ? clr_q[IAW-1:0] : cmd.row_index[IAW-1:0]]
				<= (state_q == S_CLEAR) ? 32'sd0 : cmd.operand;
		a_rd <= a_mem[i_addr];
	end

	always_ff @(posedge clk) begin
		if (e_we)
			e_mem[(state_q == S_ERRWR) ? row_q : clr_q[NAW-1:0]] <= e_wd;
		e_rd <= e_mem[e_raddr];
	end

	// payload latched on accept; step latched in S_USTEP
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q    <= cmd.row_index[NAW-1:0];
			row_ok_q <= cmd_row_n_ok;
			opnd_q   <= cmd.operand;
		end
		if (state_q == S_USTEP)
			step_q <= mul_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			bias_q      <= 1'b0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_ready)
				res_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == DEPTH - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					n_q    <= '0;
					i_q    <= '0;
					acc_q  <= '0;
					clr_q  <= '0;
					bias_q <= ni_zero;
					if (accept) begin
						case (cmd.opcode)
							OP_ERR: state_q <= S_ERRWR;
							OP_FWD: state_q <= (cfg.nn == '0) ? S_FCLR : S_FBIAS;
							OP_BWD: begin
								if (cfg.nn == '0)
									state_q <= S_IDLE;
								else if (ni_zero)
									state_q <= S_URD;
								else
									state_q <= S_BRD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ERRWR: state_q <= S_IDLE;
				S_FBIAS: state_q <= S_FBLD;
				S_FBLD: begin
					acc_q   <= ACC_W'(b_rd);
					i_q     <= '0;
					state_q <= ni_zero ? S_FEMIT : S_FRD;
				end
				S_FRD: state_q <= S_FMUL;
				S_FMUL: state_q <= S_FACC;
				S_FACC: begin
					acc_q <= acc_q + ACC_W'(mul_p);
					if (i_q + 1'b1 == cfg.ni)
						state_q <= S_FEMIT;
					else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_FEMIT: begin
					if (out_free) begin
						res_valid_q        <= 1'b1;
						res_q.kind         <= KIND_ACT;
						res_q.position     <= n_q[5:0];
						res_q.result_value <= sat32(acc_q);
						res_q.last         <= (n_q + 1'b1 == cfg.nn);
						if (n_q + 1'b1 == cfg.nn)
							state_q <= S_FCLR;
						else begin
							n_q     <= n_q + 1'b1;
							state_q <= S_FBIAS;
						end
					end
				end
				S_FCLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == MAX_NEURONS - 1)
						state_q <= S_IDLE;
				end
				S_BRD: state_q <= S_BMUL;
				S_BMUL: state_q <= S_BACC;
				S_BACC: begin
					acc_q <= acc_q + ACC_W'(mul_p);
					if (n_q + 1'b1 == cfg.nn)
						state_q <= S_BEMIT;
					else begin
						n_q     <= n_q + 1'b1;
						state_q <= S_BRD;
					end
				end
				S_BEMIT: begin
					if (out_free) begin
						res_valid_q        <= 1'b1;
						res_q.kind         <= KIND_ERR;
						res_q.position     <= i_q[5:0];
						res_q.result_value <= sat32(acc_q);
						res_q.last         <= (i_q + 1'b1 == cfg.ni);
						acc_q              <= '0;
						n_q                <= '0;
						state_q            <= S_BRD;
						if (i_q + 1'b1 == cfg.ni) begin
							i_q     <= '0;
							bias_q  <= 1'b0;
							state_q <= S_URD;
						end else
							i_q <= i_q + 1'b1;
					end
				end
				S_URD: state_q <= S_UGMUL;
				S_UGMUL: state_q <= S_UGRAD;
				S_UGRAD: state_q <= S_UDIV;
				S_UDIV: begin
					if (!div_busy)
						state_q <= S_USMUL;
				end
				S_USMUL: state_q <= S_USTEP;
				S_USTEP: state_q <= S_UUPD;
				S_UUPD: begin
					state_q <= S_URD;
					if (bias_q) begin
						i_q    <= '0;
						bias_q <= ni_zero;
						if (n_q + 1'b1 == cfg.nn)
							state_q <= S_IDLE;
						else
							n_q <= n_q + 1'b1;
					end else if (i_q + 1'b1 == cfg.ni)
						bias_q <= 1'b1;
					else
						i_q <= i_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule
`default_nettype wire

>>> sv/dlms_check.sv
// Port-level checks for the dense layer, bound to the top level.
// Depends on dlms_pkg.
`default_nettype none
module dlms_check import dlms_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_ready,
	input wire cmd_t cmd,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire res_t res
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("result word changed while stalled");

	a_fwd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.opcode == OP_FWD |=> !cmd_ready)
		else $error("ready right after forward");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.opcode != OP_FWD && cmd.opcode != OP_BWD
		|=> !$rose(res_valid))
		else $error("result from a command that gives none");
endmodule

bind dense_layer_momentum_sgd dlms_check u_dlms_check (
	.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
	.cmd(cmd), .res_valid(res_valid), .res_ready(res_ready), .res(res)
);
`default_nettype wire
